FILE: design/lcg64_pkg.sv
`default_nettype none

package lcg64_pkg;

    // Request codes carried on req_type.
    localparam logic [1:0] REQ_SEED_FIRST = 2'd0;
    localparam logic [1:0] REQ_SEED_MORE  = 2'd1;
    localparam logic [1:0] REQ_GENERATE   = 2'd2;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned HALF_W  = STATE_W / 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OUT_LSB = 16;

    // Generator constants: x' = x * LCG_MUL + LCG_ADD (mod 2^64).
    localparam logic [STATE_W-1:0] LCG_MUL = 64'd125643267795740073;
    localparam logic [STATE_W-1:0] LCG_ADD = 64'd506098983240188723;

    // Two advances folded into one affine step: x'' = x * MUL_SQ + ADD_TWICE.
    localparam logic [STATE_W-1:0] LCG_MUL_SQ    = LCG_MUL * LCG_MUL;
    localparam logic [STATE_W-1:0] LCG_ADD_TWICE = LCG_MUL * LCG_ADD + LCG_ADD;

    // Seed byte weights for the folded seed requests.
    localparam logic [STATE_W-1:0] SEED_FIRST_W      = LCG_MUL + 64'd1;
    localparam logic [STATE_W-1:0] SEED_FIRST_LAST_W = LCG_MUL_SQ + LCG_MUL;

endpackage

`default_nettype wire

FILE: design/lcg64_byte_generator.sv
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+-------------------------------------
// request   | in        | req_valid / req_stall | req_type, seed_byte, seed_last
// result    | out       | byte_valid/byte_stall | random_byte
//
// One request word is taken per cycle unless stalled; a generate request passes the
// input, then the output register. Each request is folded into one affine step
// x' = M*x + K, M and K formed at the input register. The 64-bit state is split in
// halves updated in consecutive cycles, the low half (alone giving the output byte)
// first; the low stage forms two 32x32 products, the high stage one. Reset clears
// the state to zero and empties all stages. A stalled result holds the output
// register; seed requests keep flowing under it, a generate request waits.
`default_nettype none

module lcg64_byte_generator
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  seed_byte,
    input  wire logic        seed_last,

    output logic             byte_valid,
    input  wire logic        byte_stall,
    output logic [7:0]       random_byte
);

    localparam int unsigned SW = lcg64_pkg::STATE_W;
    localparam int unsigned HW = lcg64_pkg::HALF_W;
    localparam int unsigned BW = lcg64_pkg::BYTE_W;

    // Input stage: the request reduced to its affine step.
    logic          s0_valid_reg, s0_valid_next;
    logic          s0_gen_reg,   s0_gen_next;
    logic [SW-1:0] s0_mul_reg,   s0_mul_next;
    logic [SW-1:0] s0_add_reg,   s0_add_next;

    // Low half of the state and the stage that applies it.
    logic [HW-1:0] lo_state_reg, lo_state_next;
    logic [SW-1:0] lo_prod;
    logic [HW-1:0] cross_lo;

    // High half stage, registered behind the low half.
    logic          hi_valid_reg, hi_valid_next;
    logic [HW-1:0] hi_part_reg,  hi_part_next;
    logic [HW-1:0] hi_mul_reg,   hi_mul_next;
    logic [HW-1:0] hi_state_reg, hi_state_next;
    logic [HW-1:0] hi_prod;

    // Output register.
    logic          byte_valid_reg, byte_valid_next;
    logic [BW-1:0] random_byte_reg, random_byte_next;

    logic          req_accept;
    logic          lo_fire;
    logic          out_free;
    logic [SW-1:0] seed_weight;
    logic [SW-1:0] step_const;

    // Handshake control.
    assign out_free   = !byte_valid_reg || !byte_stall;
    assign lo_fire    = s0_valid_reg && (!s0_gen_reg || out_free);
    assign req_stall  = s0_valid_reg && !lo_fire;
    assign req_accept = req_valid && !req_stall;

    // Decode a request word into multiplier, seed weight and constant term.
    always_comb
    begin
        s0_mul_next = 64'd1;
        seed_weight = '0;
        step_const  = '0;
        s0_gen_next = 1'b0;
        case (req_type)
            lcg64_pkg::REQ_SEED_FIRST:
            begin
                s0_mul_next = '0;
                if (seed_last)
                begin
                    seed_weight = lcg64_pkg::SEED_FIRST_LAST_W;
                    step_const  = lcg64_pkg::LCG_ADD_TWICE;
                end
                else
                begin
                    seed_weight = lcg64_pkg::SEED_FIRST_W;
                    step_const  = lcg64_pkg::LCG_ADD;
                end
            end
            lcg64_pkg::REQ_SEED_MORE:
            begin
                if (seed_last)
                begin
                    s0_mul_next = lcg64_pkg::LCG_MUL_SQ;
                    seed_weight = lcg64_pkg::LCG_MUL;
                    step_const  = lcg64_pkg::LCG_ADD_TWICE;
                end
                else
                begin
                    s0_mul_next = lcg64_pkg::LCG_MUL;
                    seed_weight = 64'd1;
                    step_const  = lcg64_pkg::LCG_ADD;
                end
            end
            lcg64_pkg::REQ_GENERATE:
            begin
                s0_mul_next = lcg64_pkg::LCG_MUL;
                step_const  = lcg64_pkg::LCG_ADD;
                s0_gen_next = 1'b1;
            end
            default:
            begin
                s0_mul_next = 64'd1;
            end
        endcase
        s0_add_next = seed_weight * {{(SW-BW){1'b0}}, seed_byte} + step_const;
    end

    // Input stage occupancy.
    always_comb
    begin
        if (req_accept)
        begin
            s0_valid_next = 1'b1;
        end
        else if (lo_fire)
        begin
            s0_valid_next = 1'b0;
        end
        else
        begin
            s0_valid_next = s0_valid_reg;
        end
    end

    // Low half step: full 64-bit product of the low halves plus the constant term;
    // its upper word and the cross product carry over to the high half stage.
    always_comb
    begin
        lo_prod       = {{HW{1'b0}}, s0_mul_reg[HW-1:0]} * {{HW{1'b0}}, lo_state_reg}
                        + s0_add_reg;
        cross_lo      = HW'(s0_mul_reg[SW-1:HW] * lo_state_reg);
        lo_state_next = lo_fire ? lo_prod[HW-1:0] : lo_state_reg;
        hi_valid_next = lo_fire;
        hi_part_next  = lo_prod[SW-1:HW] + cross_lo;
        hi_mul_next   = s0_mul_reg[HW-1:0];
    end

    // High half step: add the remaining cross product from the previous high half.
    always_comb
    begin
        hi_prod       = hi_mul_reg * hi_state_reg;
        hi_state_next = hi_valid_reg ? (hi_part_reg + hi_prod) : hi_state_reg;
    end

    // Output register: the byte comes from the state before this request's step.
    always_comb
    begin
        byte_valid_next  = byte_valid_reg;
        random_byte_next = random_byte_reg;
        if (out_free)
        begin
            byte_valid_next = lo_fire && s0_gen_reg;
            if (lo_fire && s0_gen_reg)
            begin
                random_byte_next = lo_state_reg[lcg64_pkg::OUT_LSB +: BW];
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            hi_valid_reg   <= 1'b0;
            byte_valid_reg <= 1'b0;
            lo_state_reg   <= '0;
            hi_state_reg   <= '0;
        end
        else
        begin
            s0_valid_reg   <= s0_valid_next;
            hi_valid_reg   <= hi_valid_next;
            byte_valid_reg <= byte_valid_next;
            lo_state_reg   <= lo_state_next;
            hi_state_reg   <= hi_state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s0_gen_reg <= s0_gen_next;
            s0_mul_reg <= s0_mul_next;
            s0_add_reg <= s0_add_next;
        end
        if (lo_fire)
        begin
            hi_part_reg <= hi_part_next;
            hi_mul_reg  <= hi_mul_next;
        end
        random_byte_reg <= random_byte_next;
    end

    assign byte_valid  = byte_valid_reg;
    assign random_byte = random_byte_reg;

`ifndef SYNTHESIS
    // The high half step always comes in the cycle after the low half step.
    assert property (@(posedge clk) disable iff (!rst_n)
        lo_fire |=> hi_valid_reg)
        else $error("high half step missing after low half step");

    assert property (@(posedge clk) disable iff (!rst_n)
        !lo_fire |=> !hi_valid_reg)
        else $error("high half step without a low half step");

    // The low half only moves when a request word passes the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        !lo_fire |=> $stable(lo_state_reg))
        else $error("low half of state changed without a request");

    // A passing generate request always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lo_fire && s0_gen_reg) |=> byte_valid_reg)
        else $error("generated byte was lost");

    // Back-pressure is raised only while the input stage holds a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s0_valid_reg)
        else $error("request stalled with an empty input stage");
`endif

endmodule

`default_nettype wire
